### rtl/assert_macros.svh
// Assertion helpers. Clock i_clk and active-low reset i_rst_n are assumed in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds on the same edge.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition holds on the following edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sddf_pkg.sv
package sddf_pkg;

    localparam int NUM_POS    = 5;
    localparam int NUM_DIGITS = 4;

    localparam logic [15:0] BLANK_CODE = 16'hFFFF;
    localparam logic [15:0] MINUS_CODE = 16'hFFFE;
    localparam logic [15:0] DEC_LIMIT  = 16'd10000;

    localparam logic CMD_DEC = 1'b0;
    localparam logic CMD_HEX = 1'b1;

    // Reciprocal multipliers, exact for values below DEC_LIMIT
    localparam logic [12:0] DIV10_MUL   = 13'd6554;   // >> 16
    localparam logic [12:0] DIV100_MUL  = 13'd5243;   // >> 19
    localparam logic [14:0] DIV1000_MUL = 15'd16778;  // >> 24

    typedef struct packed {
        logic        command;
        logic        is_positive;
        logic [15:0] magnitude;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  digit_position;
        logic [15:0] digit_code;
        logic        last;
        logic        range_error;
    } t_out_item;

    typedef logic [NUM_DIGITS-1:0][3:0] t_digits;

    // Converted item held by the write sequencer
    typedef struct packed {
        t_digits    digits;
        logic [1:0] top;   // index of most significant shown digit
        logic       neg;
        logic       err;
    } t_conv;

endpackage

### rtl/sddf_conv.sv
module sddf_conv (
    input  sddf_pkg::t_in_item i_item,
    output sddf_pkg::t_conv    o_conv
);

    logic [13:0] v14;
    logic [26:0] p10;
    logic [26:0] p100;
    logic [28:0] p1000;
    logic [9:0]  q1;
    logic [6:0]  q2;
    logic [3:0]  q3;
    logic [13:0] q1x10;
    logic [9:0]  q2x10;
    logic [6:0]  q3x10;
    logic [13:0] r0;
    logic [9:0]  r1;
    logic [6:0]  r2;
    sddf_pkg::t_digits dec_digits;
    sddf_pkg::t_digits digits;

    assign v14 = i_item.magnitude[13:0];

    // Parallel constant multiplies, no chained division
    assign p10   = 27'(v14) * 27'(sddf_pkg::DIV10_MUL);
    assign p100  = 27'(v14) * 27'(sddf_pkg::DIV100_MUL);
    assign p1000 = 29'(v14) * 29'(sddf_pkg::DIV1000_MUL);

    assign q1 = p10[25:16];
    assign q2 = p100[25:19];
    assign q3 = p1000[27:24];

    // x10 as shift-add
    assign q1x10 = {1'b0, q1, 3'b000} + {3'b000, q1, 1'b0};
    assign q2x10 = {q2, 3'b000} + {2'b00, q2, 1'b0};
    assign q3x10 = {q3, 3'b000} + {2'b00, q3, 1'b0};

    assign r0 = v14 - q1x10;
    assign r1 = q1 - q2x10;
    assign r2 = q2 - q3x10;

    assign dec_digits = {q3, r2[3:0], r1[3:0], r0[3:0]};

    always_comb begin
        if (i_item.command == sddf_pkg::CMD_HEX) begin
            digits = i_item.magnitude;
        end else begin
            digits = dec_digits;
        end

        o_conv.digits = digits;
        if (digits[3] != 4'd0) begin
            o_conv.top = 2'd3;
        end else if (digits[2] != 4'd0) begin
            o_conv.top = 2'd2;
        end else if (digits[1] != 4'd0) begin
            o_conv.top = 2'd1;
        end else begin
            o_conv.top = 2'd0;
        end
        o_conv.neg = !i_item.is_positive;
        o_conv.err = (i_item.command == sddf_pkg::CMD_DEC)
                     && (i_item.magnitude >= sddf_pkg::DEC_LIMIT);
    end

endmodule

### rtl/signed_digit_display_formatter_core.sv
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_stall    i_in_data  (sddf_pkg::t_in_item)
// output    out        o_out_valid / i_out_stall  o_out_data (sddf_pkg::t_out_item)
//
// Each item gives five display writes, one per cycle while the output is not
// stalled; a decimal range error gives one result instead.
// The single output register carries one write per transfer.
// A result passes from the input register (loaded on the input transfer)
// through the sequencer register to the output register. Reset is synchronous,
// active low, and empties all stages.
// Output stall holds the output register; the stages behind it fill and then
// stall the input.
`include "assert_macros.svh"

module signed_digit_display_formatter_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  sddf_pkg::t_in_item   i_in_data,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output sddf_pkg::t_out_item  o_out_data,
    input  logic                 i_out_stall
);

    localparam logic [2:0] LAST_IDX = 3'(sddf_pkg::NUM_POS - 1);

    // Input stage
    logic                r_s1_v, n_s1_v;
    sddf_pkg::t_in_item  r_s1, n_s1;

    // Write sequencer: converted item plus write index
    logic                r_sq_v, n_sq_v;
    sddf_pkg::t_conv     r_sq, n_sq;
    logic [2:0]          r_idx, n_idx;

    // Output register
    logic                r_out_v, n_out_v;
    sddf_pkg::t_out_item r_out, n_out;

    sddf_pkg::t_conv     conv;
    sddf_pkg::t_out_item res;

    logic out_take;
    logic emit;
    logic sq_last;
    logic sq_free;
    logic s1_move;
    logic in_take;

    sddf_conv u_conv (
        .i_item (r_s1),
        .o_conv (conv)
    );

    // Handshake glue
    assign out_take   = !r_out_v || !i_out_stall;
    assign emit       = r_sq_v && out_take;
    assign sq_last    = r_sq.err || (r_idx == LAST_IDX);
    assign sq_free    = !r_sq_v || (emit && sq_last);
    assign s1_move    = r_s1_v && sq_free;
    assign o_in_stall = r_s1_v && !sq_free;
    assign in_take    = i_in_valid && !o_in_stall;

    // Write k of a run (a range error gives one result at position 0 instead):
    //   k below the digit count  -> digit k at position k
    //   other k below 4          -> blank at position k+1 (skips the sign slot)
    //   k == 4                   -> sign code just above the top digit, last
    always_comb begin
        res.digit_position = r_idx;
        res.digit_code     = sddf_pkg::BLANK_CODE;
        res.last           = 1'b0;
        res.range_error    = 1'b0;
        if (r_sq.err) begin
            res.digit_position = 3'd0;
            res.digit_code     = 16'd0;
            res.last           = 1'b1;
            res.range_error    = 1'b1;
        end else if (r_idx == LAST_IDX) begin
            res.digit_position = {1'b0, r_sq.top} + 3'd1;
            res.digit_code     = r_sq.neg ? sddf_pkg::MINUS_CODE : sddf_pkg::BLANK_CODE;
            res.last           = 1'b1;
        end else if (r_idx[1:0] <= r_sq.top) begin
            res.digit_code     = {12'd0, r_sq.digits[r_idx[1:0]]};
        end else begin
            res.digit_position = r_idx + 3'd1;
        end
    end

    always_comb begin
        n_s1_v  = in_take || (r_s1_v && !sq_free);
        n_s1    = in_take ? i_in_data : r_s1;

        n_sq_v  = s1_move || (r_sq_v && !(emit && sq_last));
        n_sq    = s1_move ? conv : r_sq;
        if (s1_move || (emit && sq_last)) begin
            n_idx = 3'd0;
        end else if (emit) begin
            n_idx = r_idx + 3'd1;
        end else begin
            n_idx = r_idx;
        end

        n_out_v = emit || (r_out_v && i_out_stall);
        n_out   = emit ? res : r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_sq_v  <= 1'b0;
            r_idx   <= 3'd0;
            r_out_v <= 1'b0;
        end else begin
            r_s1_v  <= n_s1_v;
            r_sq_v  <= n_sq_v;
            r_idx   <= n_idx;
            r_out_v <= n_out_v;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        r_s1  <= n_s1;
        r_sq  <= n_sq;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    `ASSERT_IMPL(a_err_single, r_out_v && r_out.range_error, r_out.last && (r_out.digit_position == 3'd0), "range error result malformed")
    `ASSERT_IMPL(a_idx_range, r_sq_v, r_idx <= LAST_IDX, "write index out of range")
    `ASSERT_NEXT(a_idx_hold, r_out_v && i_out_stall, $stable(r_idx), "sequencer advanced under stall")
    `ASSERT_IMPL(a_sign_code, r_out_v && r_out.last && !r_out.range_error, (r_out.digit_code == sddf_pkg::BLANK_CODE) || (r_out.digit_code == sddf_pkg::MINUS_CODE), "last write is not a sign code")

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import sddf_pkg::*;

    // Long receiver hold-off used to back the pipeline up into the input.
    localparam int unsigned HOLD_CYCLES    = 300;
    // Cycles without any transfer before the run is declared hung.
    // Covers the hold-off plus the longest random stall streaks.
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    // Quiet cycles after the last write.
    localparam int unsigned DRAIN_CYCLES   = 20;
    localparam int unsigned RANDOM_ITEMS   = 280;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;

    // Items waiting to be offered, and display writes waiting to be seen.
    t_in_item  item_queue[$];
    t_out_item pending_writes[$];

    int unsigned sender_idle_pct   = 7;
    int unsigned receiver_idle_pct = 74;
    // Bumped by the stimulus to ask the receiver for one long hold-off.
    int unsigned hold_token  = 0;
    int unsigned hold_seen   = 0;
    int unsigned hold_left   = 0;
    int unsigned fail_count  = 0;
    int unsigned idle_cycles = 0;

    signed_digit_display_formatter_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    always #5 i_clk = ~i_clk;

    // Expected display writes for one item: digits low position first, blanks
    // above the sign slot, then the sign slot itself as the last write.
    // Decimal values at or over the limit give a single range-error result.
    function automatic void predict_writes(input t_in_item it);
        logic [3:0]  dig [NUM_DIGITS];
        int unsigned ndig;
        int unsigned q;
        t_out_item   w;
        logic [15:0] v;
        v = it.magnitude;
        if (it.command == CMD_HEX) begin
            for (int i = 0; i < NUM_DIGITS; i++) begin
                dig[i] = v[4*i +: 4];
            end
            ndig = (v < 16'h0010) ? 1 : (v < 16'h0100) ? 2 : (v < 16'h1000) ? 3 : 4;
        end else begin
            if (v >= DEC_LIMIT) begin
                w.digit_position = 3'd0;
                w.digit_code     = 16'd0;
                w.last           = 1'b1;
                w.range_error    = 1'b1;
                pending_writes.push_back(w);
                return;
            end
            q = v;
            for (int i = 0; i < NUM_DIGITS; i++) begin
                dig[i] = 4'(q % 10);
                q      = q / 10;
            end
            ndig = (v < 10) ? 1 : (v < 100) ? 2 : (v < 1000) ? 3 : 4;
        end
        w.last        = 1'b0;
        w.range_error = 1'b0;
        for (int unsigned p = 0; p < ndig; p++) begin
            w.digit_position = 3'(p);
            w.digit_code     = {12'd0, dig[p]};
            pending_writes.push_back(w);
        end
        for (int unsigned p = ndig + 1; p < NUM_POS; p++) begin
            w.digit_position = 3'(p);
            w.digit_code     = BLANK_CODE;
            pending_writes.push_back(w);
        end
        w.digit_position = 3'(ndig);
        w.digit_code     = it.is_positive ? BLANK_CODE : MINUS_CODE;
        w.last           = 1'b1;
        pending_writes.push_back(w);
    endfunction

    // Mostly values that fill a given number of digits, some full-range noise,
    // which in decimal mode lands mostly on the range error.
    function automatic t_in_item rand_item();
        t_in_item    it;
        int unsigned bucket;
        logic        hex;
        bucket         = $urandom_range(0, 9);
        hex            = 1'($urandom_range(0, 1));
        it.command     = hex ? CMD_HEX : CMD_DEC;
        it.is_positive = 1'($urandom_range(0, 1));
        case (bucket)
            0: begin
                it.magnitude = hex ? 16'($urandom_range(0, 15)) : 16'($urandom_range(0, 9));
            end
            1: begin
                it.magnitude = hex ? 16'($urandom_range(16, 255)) : 16'($urandom_range(10, 99));
            end
            2: begin
                it.magnitude = hex ? 16'($urandom_range(256, 4095))
                                   : 16'($urandom_range(100, 999));
            end
            3, 4, 5: begin
                it.magnitude = hex ? 16'($urandom_range(4096, 65535))
                                   : 16'($urandom_range(1000, 9999));
            end
            6: begin
                it.magnitude = hex ? 16'($urandom) : 16'($urandom_range(10000, 65535));
            end
            default: begin
                it.magnitude = 16'($urandom);
            end
        endcase
        return it;
    endfunction

    task automatic add_item(input logic cmd, input logic positive, input logic [15:0] mag);
        t_in_item it;
        it.command     = cmd;
        it.is_positive = positive;
        it.magnitude   = mag;
        item_queue.push_back(it);
    endtask

    task automatic add_random(input int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            item_queue.push_back(rand_item());
        end
    endtask

    // Block until every queued item went in and every write came out.
    task automatic wait_drained();
        while (item_queue.size() != 0 || i_in_valid || pending_writes.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Driver: a payload stays put while stalled; a new one is taken from the
    // queue only when the slot is free, so valid never looks at stall.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_writes(i_in_data);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (item_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                    i_in_data  <= item_queue.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each output transfer against the oldest expected write,
    // and drives the output stall, including the long hold-off on request.
    always @(posedge i_clk) begin
        t_out_item want;
        logic      bad;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_seen   <= hold_token;
            hold_left   <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_writes.size() == 0) begin
                    $display("%0t: unexpected write, actual %p", $time, o_out_data);
                    fail_count++;
                end else begin
                    want = pending_writes.pop_front();
                    bad  = 1'b0;
                    if (o_out_data.digit_position !== want.digit_position) begin
                        $display("%0t: digit_position expected %0d actual %0d",
                                 $time, want.digit_position, o_out_data.digit_position);
                        bad = 1'b1;
                    end
                    if (o_out_data.digit_code !== want.digit_code) begin
                        $display("%0t: digit_code expected %h actual %h",
                                 $time, want.digit_code, o_out_data.digit_code);
                        bad = 1'b1;
                    end
                    if (o_out_data.last !== want.last) begin
                        $display("%0t: last expected %b actual %b",
                                 $time, want.last, o_out_data.last);
                        bad = 1'b1;
                    end
                    if (o_out_data.range_error !== want.range_error) begin
                        $display("%0t: range_error expected %b actual %b",
                                 $time, want.range_error, o_out_data.range_error);
                        bad = 1'b1;
                    end
                    if (bad) begin
                        fail_count++;
                    end
                end
            end
            if (hold_token != hold_seen) begin
                hold_seen   <= hold_token;
                hold_left   <= HOLD_CYCLES;
                i_out_stall <= 1'b1;
            end else if (hold_left != 0) begin
                hold_left   <= hold_left - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
            end
        end
    end

    // Watchdog: any transfer on either side resets the count.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus. All queue and knob updates happen on the falling edge so the
    // clocked processes never race them.
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Phase one: sender mostly busy, receiver mostly stalled.
        sender_idle_pct   = 7;
        receiver_idle_pct = 74;

        // Directed: digit-count boundaries in both bases, zero with both signs
        // (negative zero shows a minus), the largest in-range decimal value, the
        // first value past the decimal range with both signs, and 65535.
        add_item(CMD_HEX, 1'b1, 16'h0000);
        add_item(CMD_HEX, 1'b0, 16'h0000);
        add_item(CMD_HEX, 1'b0, 16'h000F);
        add_item(CMD_HEX, 1'b1, 16'h0010);
        add_item(CMD_HEX, 1'b0, 16'h00FF);
        add_item(CMD_HEX, 1'b1, 16'h0100);
        add_item(CMD_HEX, 1'b0, 16'h0FFF);
        add_item(CMD_HEX, 1'b1, 16'h1000);
        add_item(CMD_HEX, 1'b0, 16'hFFFF);
        add_item(CMD_HEX, 1'b1, 16'hFFFF);
        add_item(CMD_DEC, 1'b1, 16'd0);
        add_item(CMD_DEC, 1'b0, 16'd0);
        add_item(CMD_DEC, 1'b0, 16'd9);
        add_item(CMD_DEC, 1'b1, 16'd10);
        add_item(CMD_DEC, 1'b0, 16'd99);
        add_item(CMD_DEC, 1'b1, 16'd100);
        add_item(CMD_DEC, 1'b0, 16'd999);
        add_item(CMD_DEC, 1'b1, 16'd1000);
        add_item(CMD_DEC, 1'b0, 16'd9999);
        add_item(CMD_DEC, 1'b1, 16'd10000);
        add_item(CMD_DEC, 1'b0, 16'd10000);
        add_item(CMD_DEC, 1'b1, 16'd65535);
        wait_drained();

        // Random with a long receiver hold-off while items keep coming, so the
        // block fills and stalls its input.
        add_random(45);
        hold_token++;
        add_random(45);
        wait_drained();

        // Phase two: sender mostly idle, receiver mostly ready. Midway the
        // sender pauses until every write has come out.
        sender_idle_pct   = 74;
        receiver_idle_pct = 7;
        add_random(45);
        wait_drained();
        add_random(50);
        wait_drained();

        // Phase three: full rate on both sides.
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        add_random(RANDOM_ITEMS - 185);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_writes.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
